@@ hdl/ple_pkg.sv @@
// Shared types, constants and codes for the positional list engine.
package ple_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int POS_W    = 6;
    localparam int LEN_W    = 6;
    localparam int CMD_W    = 4;
    localparam int STS_W    = 3;
    localparam int CMP_W    = (POS_W > CNT_W + 1) ? POS_W : CNT_W + 1;

    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [POS_W-1:0]        pos_t;
    typedef logic [LEN_W-1:0]        len_t;
    typedef logic [CMP_W-1:0]        cmp_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 4'd0,
        CMD_PUSH_BACK  = 4'd1,
        CMD_INSERT_AT  = 4'd2,
        CMD_POP_FRONT  = 4'd3,
        CMD_POP_BACK   = 4'd4,
        CMD_DELETE_AT  = 4'd5,
        CMD_SEARCH     = 4'd6,
        CMD_MODIFY_AT  = 4'd7,
        CMD_REVERSE    = 4'd8,
        CMD_DUMP       = 4'd9
    } cmd_t;

    typedef enum logic [STS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_NOPOS    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_PUT,
        S_SEARCH,
        S_REV,
        S_DUMP,
        S_RESP
    } state_t;

    // One result beat.
    typedef struct packed {
        status_t status;
        val_t    value;
        pos_t    fpos;
        len_t    length;
        logic    last;
    } res_t;

    typedef struct packed {
        logic valid;
        res_t res;
    } push_t;

    // Element store access for one cycle.
    typedef struct packed {
        logic we;
        idx_t waddr;
        val_t wdata;
        logic re;
        idx_t raddr;
    } mem_req_t;

endpackage

@@ hdl/ple_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/ple_out.sv @@
// Output register for result beats.
module ple_out (
    input  logic            clk,
    input  logic            rst_n,
    input  ple_pkg::push_t  push,
    output logic            push_ok,
    output logic            out_valid,
    input  logic            out_ready,
    output ple_pkg::res_t   res
);

    logic          valid_reg, valid_next;
    ple_pkg::res_t res_reg, res_next;

    // Take a new beat when the register is empty or being drained.
    assign push_ok = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (push_ok)
        begin
            valid_next = push.valid;
            if (push.valid)
            begin
                res_next = push.res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;

endmodule

@@ hdl/ple_ctrl.sv @@
// Command sequencer: walks the element store through its single read port.
module ple_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         cmd,
    input  ple_pkg::val_t      item_value,
    input  ple_pkg::pos_t      item_position,
    output ple_pkg::mem_req_t  mem,
    input  ple_pkg::val_t      rdata,
    output ple_pkg::push_t     push,
    input  logic               push_ok,
    output ple_pkg::cnt_t      count
);

    ple_pkg::state_t  state_reg, state_next;
    ple_pkg::cnt_t    count_reg, count_next;
    ple_pkg::val_t    value_reg, value_next;
    ple_pkg::status_t status_reg, status_next;
    ple_pkg::pos_t    fpos_reg, fpos_next;
    ple_pkg::idx_t    put_idx_reg, put_idx_next;
    logic             ins_reg, ins_next;
    ple_pkg::idx_t    src_reg, src_next;
    ple_pkg::cnt_t    rem_reg, rem_next;
    logic             mv_pend_reg, mv_pend_next;
    ple_pkg::idx_t    mv_dst_reg, mv_dst_next;
    ple_pkg::cnt_t    rd_idx_reg, rd_idx_next;
    logic             pend_reg, pend_next;
    ple_pkg::idx_t    pend_idx_reg, pend_idx_next;
    ple_pkg::idx_t    lo_reg, lo_next;
    ple_pkg::idx_t    hi_reg, hi_next;
    logic             phase_reg, phase_next;
    logic             wlo_pend_reg, wlo_pend_next;
    ple_pkg::idx_t    wlo_addr_reg, wlo_addr_next;
    logic             whi_pend_reg, whi_pend_next;
    ple_pkg::idx_t    whi_addr_reg, whi_addr_next;
    ple_pkg::val_t    tmp_reg, tmp_next;

    ple_pkg::cmp_t    pos_cmp, n_cmp;
    logic             pos_ins_ok, pos_del_ok, full, empty, dump_last;
    ple_pkg::idx_t    pos_idx, n_last;

    assign pos_cmp    = ple_pkg::cmp_t'(item_position);
    assign n_cmp      = ple_pkg::cmp_t'(count_reg);
    assign pos_ins_ok = (pos_cmp != '0) && (pos_cmp <= n_cmp + ple_pkg::cmp_t'(1));
    assign pos_del_ok = (pos_cmp != '0) && (pos_cmp <= n_cmp);
    assign full       = (n_cmp >= ple_pkg::cmp_t'(ple_pkg::CAPACITY));
    assign empty      = (count_reg == '0);
    assign pos_idx    = ple_pkg::idx_t'(item_position - ple_pkg::pos_t'(1));
    assign n_last     = ple_pkg::idx_t'(count_reg - ple_pkg::cnt_t'(1));
    assign dump_last  = (ple_pkg::cnt_t'(pend_idx_reg) + ple_pkg::cnt_t'(1) == count_reg);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        value_next    = value_reg;
        status_next   = status_reg;
        fpos_next     = fpos_reg;
        put_idx_next  = put_idx_reg;
        ins_next      = ins_reg;
        src_next      = src_reg;
        rem_next      = rem_reg;
        mv_pend_next  = 1'b0;
        mv_dst_next   = mv_dst_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        phase_next    = phase_reg;
        wlo_pend_next = wlo_pend_reg;
        wlo_addr_next = wlo_addr_reg;
        whi_pend_next = whi_pend_reg;
        whi_addr_next = whi_addr_reg;
        tmp_next      = tmp_reg;

        in_ready  = 1'b0;
        mem       = '0;
        push      = '0;
        push.res.status = status_reg;
        push.res.fpos   = fpos_reg;
        push.res.length = ple_pkg::len_t'(count_reg);
        push.res.last   = 1'b1;

        unique case (state_reg)
            ple_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    value_next  = item_value;
                    status_next = ple_pkg::ST_OK;
                    fpos_next   = '0;
                    pend_next   = 1'b0;
                    rd_idx_next = '0;
                    state_next  = ple_pkg::S_RESP;
                    unique case (ple_pkg::cmd_t'(cmd))
                        ple_pkg::CMD_PUSH_FRONT, ple_pkg::CMD_PUSH_BACK,
                        ple_pkg::CMD_INSERT_AT:
                        begin
                            ins_next = 1'b1;
                            src_next = n_last;
                            if (full)
                            begin
                                status_next = ple_pkg::ST_FULL;
                            end
                            else if (ple_pkg::cmd_t'(cmd) == ple_pkg::CMD_PUSH_FRONT || empty)
                            begin
                                put_idx_next = '0;
                                rem_next     = count_reg;
                                state_next   = ple_pkg::S_MOVE;
                            end
                            else if (ple_pkg::cmd_t'(cmd) == ple_pkg::CMD_PUSH_BACK)
                            begin
                                put_idx_next = ple_pkg::idx_t'(count_reg);
                                rem_next     = '0;
                                state_next   = ple_pkg::S_MOVE;
                            end
                            else if (pos_ins_ok)
                            begin
                                put_idx_next = pos_idx;
                                rem_next     = count_reg - ple_pkg::cnt_t'(pos_idx);
                                state_next   = ple_pkg::S_MOVE;
                            end
                            else
                            begin
                                status_next = ple_pkg::ST_NOPOS;
                            end
                        end
                        ple_pkg::CMD_POP_FRONT, ple_pkg::CMD_POP_BACK,
                        ple_pkg::CMD_DELETE_AT:
                        begin
                            ins_next = 1'b0;
                            if (empty)
                            begin
                                status_next = ple_pkg::ST_EMPTY;
                            end
                            else if (ple_pkg::cmd_t'(cmd) == ple_pkg::CMD_POP_FRONT)
                            begin
                                src_next   = ple_pkg::idx_t'(1);
                                rem_next   = count_reg - ple_pkg::cnt_t'(1);
                                state_next = ple_pkg::S_MOVE;
                            end
                            else if (ple_pkg::cmd_t'(cmd) == ple_pkg::CMD_POP_BACK)
                            begin
                                rem_next   = '0;
                                state_next = ple_pkg::S_MOVE;
                            end
                            else if (pos_del_ok)
                            begin
                                src_next   = pos_idx + ple_pkg::idx_t'(1);
                                rem_next   = count_reg - ple_pkg::cnt_t'(pos_idx)
                                             - ple_pkg::cnt_t'(1);
                                state_next = ple_pkg::S_MOVE;
                            end
                            else
                            begin
                                status_next = ple_pkg::ST_NOPOS;
                            end
                        end
                        ple_pkg::CMD_SEARCH:
                        begin
                            if (empty)
                            begin
                                status_next = ple_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                status_next = ple_pkg::ST_NOTFOUND;
                                state_next  = ple_pkg::S_SEARCH;
                            end
                        end
                        ple_pkg::CMD_MODIFY_AT:
                        begin
                            if (empty)
                            begin
                                status_next = ple_pkg::ST_EMPTY;
                            end
                            else if (pos_del_ok)
                            begin
                                mem.we    = 1'b1;
                                mem.waddr = pos_idx;
                                mem.wdata = item_value;
                            end
                            else
                            begin
                                status_next = ple_pkg::ST_NOPOS;
                            end
                        end
                        ple_pkg::CMD_REVERSE:
                        begin
                            lo_next       = '0;
                            hi_next       = n_last;
                            phase_next    = 1'b0;
                            wlo_pend_next = 1'b0;
                            whi_pend_next = 1'b0;
                            if (empty)
                            begin
                                status_next = ple_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = ple_pkg::S_REV;
                            end
                        end
                        ple_pkg::CMD_DUMP:
                        begin
                            if (empty)
                            begin
                                status_next = ple_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = ple_pkg::S_DUMP;
                            end
                        end
                        default:
                        begin
                            status_next = ple_pkg::ST_OK;
                        end
                    endcase
                end
            end

            ple_pkg::S_MOVE:
            begin
                // Write back the element read last cycle one slot over.
                if (mv_pend_reg)
                begin
                    mem.we    = 1'b1;
                    mem.waddr = mv_dst_reg;
                    mem.wdata = rdata;
                end
                if (rem_reg != '0)
                begin
                    mem.re       = 1'b1;
                    mem.raddr    = src_reg;
                    mv_pend_next = 1'b1;
                    mv_dst_next  = ins_reg ? src_reg + ple_pkg::idx_t'(1)
                                           : src_reg - ple_pkg::idx_t'(1);
                    src_next     = ins_reg ? src_reg - ple_pkg::idx_t'(1)
                                           : src_reg + ple_pkg::idx_t'(1);
                    rem_next     = rem_reg - ple_pkg::cnt_t'(1);
                end
                else if (!mv_pend_reg)
                begin
                    if (ins_reg)
                    begin
                        state_next = ple_pkg::S_PUT;
                    end
                    else
                    begin
                        count_next = count_reg - ple_pkg::cnt_t'(1);
                        state_next = ple_pkg::S_RESP;
                    end
                end
            end

            ple_pkg::S_PUT:
            begin
                mem.we     = 1'b1;
                mem.waddr  = put_idx_reg;
                mem.wdata  = value_reg;
                count_next = count_reg + ple_pkg::cnt_t'(1);
                state_next = ple_pkg::S_RESP;
            end

            ple_pkg::S_SEARCH:
            begin
                if (pend_reg && rdata == value_reg)
                begin
                    status_next = ple_pkg::ST_OK;
                    fpos_next   = ple_pkg::pos_t'(ple_pkg::cnt_t'(pend_idx_reg)
                                                  + ple_pkg::cnt_t'(1));
                    pend_next   = 1'b0;
                    state_next  = ple_pkg::S_RESP;
                end
                else if (rd_idx_reg < count_reg)
                begin
                    mem.re        = 1'b1;
                    mem.raddr     = ple_pkg::idx_t'(rd_idx_reg);
                    pend_next     = 1'b1;
                    pend_idx_next = ple_pkg::idx_t'(rd_idx_reg);
                    rd_idx_next   = rd_idx_reg + ple_pkg::cnt_t'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ple_pkg::S_RESP;
                end
            end

            ple_pkg::S_REV:
            begin
                phase_next = !phase_reg;
                if (!phase_reg)
                begin
                    if (wlo_pend_reg)
                    begin
                        mem.we    = 1'b1;
                        mem.waddr = wlo_addr_reg;
                        mem.wdata = rdata;
                    end
                    wlo_pend_next = 1'b0;
                    if (lo_reg < hi_reg)
                    begin
                        mem.re    = 1'b1;
                        mem.raddr = lo_reg;
                    end
                end
                else
                begin
                    if (whi_pend_reg)
                    begin
                        mem.we    = 1'b1;
                        mem.waddr = whi_addr_reg;
                        mem.wdata = tmp_reg;
                    end
                    whi_pend_next = 1'b0;
                    tmp_next      = rdata;
                    if (lo_reg < hi_reg)
                    begin
                        mem.re        = 1'b1;
                        mem.raddr     = hi_reg;
                        wlo_pend_next = 1'b1;
                        wlo_addr_next = lo_reg;
                        whi_pend_next = 1'b1;
                        whi_addr_next = hi_reg;
                        lo_next       = lo_reg + ple_pkg::idx_t'(1);
                        hi_next       = hi_reg - ple_pkg::idx_t'(1);
                    end
                    else
                    begin
                        state_next = ple_pkg::S_RESP;
                    end
                end
            end

            ple_pkg::S_DUMP:
            begin
                push.valid      = pend_reg;
                push.res.status = ple_pkg::ST_OK;
                push.res.value  = rdata;
                push.res.fpos   = '0;
                push.res.last   = dump_last;
                // Hold the read data while the output stalls.
                if (!pend_reg || push_ok)
                begin
                    if (pend_reg && dump_last)
                    begin
                        pend_next  = 1'b0;
                        state_next = ple_pkg::S_IDLE;
                    end
                    else if (rd_idx_reg < count_reg)
                    begin
                        mem.re        = 1'b1;
                        mem.raddr     = ple_pkg::idx_t'(rd_idx_reg);
                        pend_next     = 1'b1;
                        pend_idx_next = ple_pkg::idx_t'(rd_idx_reg);
                        rd_idx_next   = rd_idx_reg + ple_pkg::cnt_t'(1);
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end
            end

            ple_pkg::S_RESP:
            begin
                push.valid = 1'b1;
                if (push_ok)
                begin
                    state_next = ple_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ple_pkg::S_IDLE;
            count_reg    <= '0;
            mv_pend_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            phase_reg    <= 1'b0;
            wlo_pend_reg <= 1'b0;
            whi_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            mv_pend_reg  <= mv_pend_next;
            pend_reg     <= pend_next;
            phase_reg    <= phase_next;
            wlo_pend_reg <= wlo_pend_next;
            whi_pend_reg <= whi_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        status_reg   <= status_next;
        fpos_reg     <= fpos_next;
        put_idx_reg  <= put_idx_next;
        ins_reg      <= ins_next;
        src_reg      <= src_next;
        rem_reg      <= rem_next;
        mv_dst_reg   <= mv_dst_next;
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        wlo_addr_reg <= wlo_addr_next;
        whi_addr_reg <= whi_addr_next;
        tmp_reg      <= tmp_next;
    end

    assign count = count_reg;

endmodule

@@ hdl/positional_list_engine.sv @@
// Top level of the positional list engine: sequencer, element RAM and result register.
//
// Bounded ordered list of up to 32 signed 32-bit values, addressed by 1-based
// position, held in one 32x32 RAM with one write port and one registered read
// port. One command is taken at a time: in_ready is high only while the
// sequencer is idle, and every command gives one result beat, except a dump of
// a non-empty list, which gives one beat per element with last set on the
// final one. Every beat carries the list length after the command. Command cost
// is set by the single RAM read port: an insert at index i of an n-element list
// moves m = n-i elements and a delete moves m = n-1-i, one element per cycle; a
// search reads one element per cycle up to the first match; a reverse swaps one
// pair at a time from both ends inward; a dump streams one element per cycle
// once the first read returns, while out_ready stays high. Results wait in an
// output register, so the engine frees up for the next command while a beat is
// still unclaimed. The RAM needs no clearing after reset: only entries below the
// length are ever read.
module positional_list_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [3:0]           cmd,
    input  logic signed [31:0]   item_value,
    input  logic [5:0]           item_position,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           status,
    output logic signed [31:0]   out_value,
    output logic [5:0]           found_position,
    output logic [5:0]           list_length,
    output logic                 last
);

    ple_pkg::mem_req_t mem;
    ple_pkg::val_t     rdata;
    ple_pkg::push_t    push;
    logic              push_ok;
    ple_pkg::res_t     res;
    ple_pkg::cnt_t     count;

    // Sequencer: decode, shift, search, reverse and dump walks.
    ple_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .item_value    (item_value),
        .item_position (item_position),
        .mem           (mem),
        .rdata         (rdata),
        .push          (push),
        .push_ok       (push_ok),
        .count         (count)
    );

    // Element store: position k lives at address k-1.
    ple_ram #(
        .WIDTH (ple_pkg::VAL_W),
        .DEPTH (ple_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .re    (mem.re),
        .raddr (mem.raddr),
        .rdata (rdata)
    );

    // Result register: hold a beat until it is taken.
    ple_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_ok   (push_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign status         = res.status;
    assign out_value      = res.value;
    assign found_position = res.fpos;
    assign list_length    = res.length;
    assign last           = res.last;

    // The list never outgrows the store.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ple_pkg::cmp_t'(count) <= ple_pkg::cmp_t'(ple_pkg::CAPACITY))
        else $error("list length beyond capacity");

    // The sequencer leaves idle once it takes a command.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command accepted while previous one still in flight");

    // The walks never read and write one entry in the same cycle.
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        mem.we && mem.re |-> mem.waddr != mem.raddr)
        else $error("read and write of the same RAM entry in one cycle");

    // Only dump beats can be non-final, and they are always OK.
    a_nonlast_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> status == ple_pkg::ST_OK)
        else $error("non-final beat with error status");

endmodule

@@ test/positional_list_engine_test.sv @@
// Self-checking testbench for the positional list engine: shadow list, random traffic, stalls.
module positional_list_engine_test;

    // Unused command codes: the engine answers them with a plain ok beat.
    localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
    localparam int         STALL_LIMIT   = 2000;  // cycles with no beat on either side
    localparam int         LONG_HOLD     = 80;    // receiver hold-off, well past one command
    localparam int         DRAIN_CYCLES  = 60;    // settle time after the last beat

    // Shadow copy of the list; works out the beats each accepted command must produce
    // and checks returned beats against them in order.
    class list_shadow;
        ple_pkg::val_t elems [ple_pkg::CAPACITY];
        int unsigned   count;
        ple_pkg::res_t expected_beats [$];
        int            errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void queue_beat(ple_pkg::status_t st, ple_pkg::val_t v, ple_pkg::pos_t fp,
                                 logic fin);
            ple_pkg::res_t r;
            r.status = st;
            r.value  = v;
            r.fpos   = fp;
            r.length = ple_pkg::len_t'(count);
            r.last   = fin;
            expected_beats.push_back(r);
        endfunction

        function void place(int unsigned idx, ple_pkg::val_t v);
            for (int unsigned i = count; i > idx; i--)
                elems[i] = elems[i-1];
            elems[idx] = v;
            count++;
        endfunction

        function void remove(int unsigned idx);
            for (int unsigned i = idx; i + 1 < count; i++)
                elems[i] = elems[i+1];
            count--;
        endfunction

        function void note_command(logic [3:0] code, ple_pkg::val_t v, ple_pkg::pos_t p);
            int unsigned      n;
            ple_pkg::status_t st;
            ple_pkg::pos_t    fp;
            ple_pkg::val_t    t;
            n  = count;
            st = ple_pkg::ST_OK;
            fp = '0;
            case (code)
                ple_pkg::CMD_PUSH_FRONT, ple_pkg::CMD_PUSH_BACK, ple_pkg::CMD_INSERT_AT:
                begin
                    // Full check comes ahead of any position check.
                    if (n >= ple_pkg::CAPACITY)
                        st = ple_pkg::ST_FULL;
                    else if (code == ple_pkg::CMD_PUSH_FRONT || n == 0)
                        place(0, v);
                    else if (code == ple_pkg::CMD_PUSH_BACK)
                        place(n, v);
                    else if (p >= 1 && p <= n + 1)
                        place(p - 1, v);
                    else
                        st = ple_pkg::ST_NOPOS;
                end
                ple_pkg::CMD_POP_FRONT, ple_pkg::CMD_POP_BACK, ple_pkg::CMD_DELETE_AT:
                begin
                    if (n == 0)
                        st = ple_pkg::ST_EMPTY;
                    else if (code == ple_pkg::CMD_POP_FRONT)
                        remove(0);
                    else if (code == ple_pkg::CMD_POP_BACK)
                        remove(n - 1);
                    else if (p >= 1 && p <= n)
                        remove(p - 1);
                    else
                        st = ple_pkg::ST_NOPOS;
                end
                ple_pkg::CMD_SEARCH:
                begin
                    if (n == 0)
                        st = ple_pkg::ST_EMPTY;
                    else
                    begin
                        st = ple_pkg::ST_NOTFOUND;
                        for (int unsigned i = 0; i < n; i++)
                        begin
                            if (elems[i] == v && st != ple_pkg::ST_OK)
                            begin
                                st = ple_pkg::ST_OK;
                                fp = ple_pkg::pos_t'(i + 1);
                            end
                        end
                    end
                end
                ple_pkg::CMD_MODIFY_AT:
                begin
                    if (n == 0)
                        st = ple_pkg::ST_EMPTY;
                    else if (p >= 1 && p <= n)
                        elems[p - 1] = v;
                    else
                        st = ple_pkg::ST_NOPOS;
                end
                ple_pkg::CMD_REVERSE:
                begin
                    if (n == 0)
                        st = ple_pkg::ST_EMPTY;
                    else
                    begin
                        for (int unsigned i = 0; i < n / 2; i++)
                        begin
                            t               = elems[i];
                            elems[i]        = elems[n - 1 - i];
                            elems[n - 1 - i] = t;
                        end
                    end
                end
                ple_pkg::CMD_DUMP:
                begin
                    if (n == 0)
                        st = ple_pkg::ST_EMPTY;
                    else
                    begin
                        for (int unsigned i = 0; i < n; i++)
                            queue_beat(ple_pkg::ST_OK, elems[i], '0, i + 1 == n);
                        return;
                    end
                end
                default: ;
            endcase
            queue_beat(st, '0, fp, 1'b1);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch on %s: got %0h, expected %0h", what, got, want);
            errors++;
        endtask

        task check_beat(logic [2:0] st, logic [31:0] v, logic [5:0] fp, logic [5:0] len,
                        logic fin);
            ple_pkg::res_t r;
            if (expected_beats.size() == 0)
            begin
                report("beat with nothing outstanding", {29'd0, st}, '0);
                return;
            end
            r = expected_beats.pop_front();
            if (st !== r.status)
                report("status", {29'd0, st}, {29'd0, r.status});
            if (v !== r.value)
                report("out_value", v, r.value);
            if (fp !== r.fpos)
                report("found_position", {26'd0, fp}, {26'd0, r.fpos});
            if (len !== r.length)
                report("list_length", {26'd0, len}, {26'd0, r.length});
            if (fin !== r.last)
                report("last", {31'd0, fin}, {31'd0, r.last});
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [3:0]         cmd;
    logic signed [31:0] item_value;
    logic [5:0]         item_position;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         status;
    logic signed [31:0] out_value;
    logic [5:0]         found_position;
    logic [5:0]         list_length;
    logic               last;

    list_shadow sb;
    int         send_max;   // sender's largest gap for the current phase
    int         recv_max;   // receiver's largest gap, toggled every so many beats
    bit         hold_req;   // ask the receiver for one long hold-off

    positional_list_engine uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one command beat: idle for a random gap, then hold valid until taken.
    // Valid is only dropped when a gap is wanted, so back-to-back beats keep it high.
    task automatic send_cmd(logic [3:0] c, ple_pkg::val_t v, ple_pkg::pos_t p);
        int gap;
        gap = $urandom_range(0, send_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= c;
        item_value    <= v;
        item_position <= p;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_command(c, v, p);
    endtask

    // Mostly a small pool of values so searches hit and duplicates occur.
    function automatic ple_pkg::val_t pick_value();
        int k;
        if ($urandom_range(0, 3) != 0)
        begin
            k = $urandom_range(0, 7);
            return k - 3;
        end
        return $urandom;
    endfunction

    // Mostly a legal insert position for the current length, sometimes anything.
    function automatic ple_pkg::pos_t pick_position(int unsigned n);
        if ($urandom_range(0, 9) < 8)
            return ple_pkg::pos_t'($urandom_range(1, n + 1));
        return ple_pkg::pos_t'($urandom_range(0, 63));
    endfunction

    function automatic logic [3:0] pick_cmd(int ins_pct, int del_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
        begin
            case ($urandom_range(0, 2))
                0:       return ple_pkg::CMD_PUSH_FRONT;
                1:       return ple_pkg::CMD_PUSH_BACK;
                default: return ple_pkg::CMD_INSERT_AT;
            endcase
        end
        if (r < ins_pct + del_pct)
        begin
            case ($urandom_range(0, 2))
                0:       return ple_pkg::CMD_POP_FRONT;
                1:       return ple_pkg::CMD_POP_BACK;
                default: return ple_pkg::CMD_DELETE_AT;
            endcase
        end
        if (r < 97)
        begin
            case ($urandom_range(0, 5))
                0, 1:    return ple_pkg::CMD_SEARCH;
                2, 3:    return ple_pkg::CMD_MODIFY_AT;
                4:       return ple_pkg::CMD_REVERSE;
                default: return ple_pkg::CMD_DUMP;
            endcase
        end
        return 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    endfunction

    task automatic run_mix(int items, int ins_pct, int del_pct);
        repeat (items)
            send_cmd(pick_cmd(ins_pct, del_pct), pick_value(), pick_position(sb.count));
    endtask

    // Pause the sender until every outstanding beat has come back.
    // Drop valid first so the last command is not offered again.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Receiver: random ready gaps, one long hold-off on request, check each beat.
    initial
    begin
        int gap;
        int beats;
        out_ready = 1'b0;
        beats     = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                gap = $urandom_range(0, recv_max);
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            sb.check_beat(status, out_value, found_position, list_length, last);
            beats++;
            // Alternate between stalling and free-running stretches.
            if (beats % 50 == 0)
                recv_max = (recv_max == 0) ? 8 : 0;
            @(negedge clk);
        end
    end

    // Watchdog: end the run if neither side moves a beat for too long.
    initial
    begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("positional_list_engine_test NOT OK");
        $finish;
    end

    initial
    begin
        sb            = new();
        send_max      = 3;
        recv_max      = 8;
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        cmd           = '0;
        item_value    = '0;
        item_position = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Every command that needs a non-empty list, on an empty list, then an unused code with all input bits set.
        send_cmd(ple_pkg::CMD_POP_FRONT, 32'sd7, 6'd1);
        send_cmd(ple_pkg::CMD_POP_BACK,  32'sd7, 6'd1);
        send_cmd(ple_pkg::CMD_DELETE_AT, 32'sd7, 6'd1);
        send_cmd(ple_pkg::CMD_SEARCH,    32'sd0, 6'd0);
        send_cmd(ple_pkg::CMD_MODIFY_AT, 32'sd9, 6'd1);
        send_cmd(ple_pkg::CMD_REVERSE,   32'sd0, 6'd0);
        send_cmd(ple_pkg::CMD_DUMP,      32'sd0, 6'd0);
        send_cmd(CMD_UNUSED_HI, -32'sd1, 6'd63);
        // Insert on an empty list ignores the position; then position 2 on one element.
        send_cmd(ple_pkg::CMD_INSERT_AT, 32'sd11, 6'd0);
        send_cmd(ple_pkg::CMD_INSERT_AT, 32'sd22, 6'd2);
        send_cmd(ple_pkg::CMD_PUSH_FRONT, 32'sh7fffffff, 6'd0);
        send_cmd(ple_pkg::CMD_PUSH_BACK,  32'sh80000000, 6'd0);
        // Positions outside 1 to length+1 are refused; length+1 and 1 are taken.
        send_cmd(ple_pkg::CMD_INSERT_AT, 32'sd1, 6'd0);
        send_cmd(ple_pkg::CMD_INSERT_AT, 32'sd1, 6'd63);
        send_cmd(ple_pkg::CMD_INSERT_AT, 32'sd33, 6'd5);
        send_cmd(ple_pkg::CMD_INSERT_AT, -32'sd5, 6'd1);
        send_cmd(ple_pkg::CMD_SEARCH,    32'sd22, 6'd0);
        send_cmd(ple_pkg::CMD_SEARCH,    32'sd12345, 6'd0);
        send_cmd(ple_pkg::CMD_MODIFY_AT, 32'sd44, 6'd6);
        send_cmd(ple_pkg::CMD_MODIFY_AT, 32'sd45, 6'd7);
        send_cmd(ple_pkg::CMD_DELETE_AT, 32'sd0, 6'd7);
        send_cmd(ple_pkg::CMD_DELETE_AT, 32'sd0, 6'd3);
        send_cmd(ple_pkg::CMD_DELETE_AT, 32'sd0, 6'd0);
        send_cmd(ple_pkg::CMD_REVERSE,   32'sd0, 6'd0);
        send_cmd(ple_pkg::CMD_DUMP,      32'sd0, 6'd0);
        wait_drained();

        // Fill to capacity back to back, then push against the full list, and search, reverse and dump it.
        send_max = 0;
        while (sb.count < ple_pkg::CAPACITY)
            send_cmd(pick_cmd(100, 0), $urandom, pick_position(sb.count));
        send_cmd(ple_pkg::CMD_PUSH_FRONT, pick_value(), 6'd1);
        send_cmd(ple_pkg::CMD_PUSH_BACK,  pick_value(), 6'd1);
        send_cmd(ple_pkg::CMD_INSERT_AT,  pick_value(), 6'd63);
        send_cmd(ple_pkg::CMD_SEARCH,     pick_value(), 6'd0);
        send_cmd(ple_pkg::CMD_REVERSE,    32'sd0, 6'd0);
        send_cmd(ple_pkg::CMD_DUMP,       32'sd0, 6'd0);
        wait_drained();

        // Balanced traffic with a long receiver hold-off so the input side backs up.
        send_max = 8;
        hold_req = 1'b1;
        run_mix(20, 35, 30);
        wait_drained();

        // Shrink, then drain to empty.
        run_mix(20, 10, 60);
        while (sb.count > 0)
            send_cmd(pick_cmd(0, 100), pick_value(),
                     ple_pkg::pos_t'($urandom_range(1, sb.count)));
        wait_drained();

        send_max = 2;
        run_mix(15, 60, 10);

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("positional_list_engine_test OK");
        else
            $display("positional_list_engine_test NOT OK");
        $finish;
    end

endmodule
